// ===== src/sipp_pkg.sv =====
package sipp_pkg;

  localparam int unsigned PhaseWidth = 3;

  localparam logic [PhaseWidth-1:0] PH_HUNT1 = 3'd0;
  localparam logic [PhaseWidth-1:0] PH_HUNT2 = 3'd1;
  localparam logic [PhaseWidth-1:0] PH_ID    = 3'd2;
  localparam logic [PhaseWidth-1:0] PH_LEN   = 3'd3;
  localparam logic [PhaseWidth-1:0] PH_INSTR = 3'd4;
  localparam logic [PhaseWidth-1:0] PH_PARAM = 3'd5;
  localparam logic [PhaseWidth-1:0] PH_CSUM  = 3'd6;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_HEADER1  = 3'd1;
  localparam logic [2:0] ERR_HEADER2  = 3'd2;
  localparam logic [2:0] ERR_LENGTH   = 3'd3;
  localparam logic [2:0] ERR_CHECKSUM = 3'd4;

  localparam logic [7:0] HeaderByte = 8'hFF;
  localparam logic [7:0] MinLength  = 8'd2;
  localparam int unsigned NumKept   = 3;

  typedef struct packed {
    logic [2:0] error_code;
    logic [7:0] device_id;
    logic [7:0] instruction;
    logic [7:0] param_first;
    logic [7:0] param_second;
    logic [7:0] param_third;
    logic [7:0] param_count;
  } result_t;

  typedef struct packed {
    logic [PhaseWidth-1:0] phase;
    logic [7:0]            held_id;
    logic [7:0]            held_length;
    logic [7:0]            held_instruction;
    logic [NumKept-1:0][7:0] held_params;
    logic [7:0]            params_seen;
    logic [7:0]            running_sum;
  } parse_state_t;

endpackage

// ===== src/sipp_if.sv =====
interface sipp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sipp_result_if;
  logic                 valid;
  logic                 ready;
  sipp_pkg::result_t    result;

  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

// ===== src/sipp_step.sv =====
module sipp_step (
  input  sipp_pkg::parse_state_t state_i,
  input  logic [7:0]             rx_byte_i,
  output sipp_pkg::parse_state_t state_o,
  output logic                   emit_o,
  output sipp_pkg::result_t      result_o
);
  import sipp_pkg::*;

  parse_state_t clear_st;
  logic [7:0]   sum_next;
  logic [7:0]   seen_next;
  logic [7:0]   nparams;

  assign sum_next  = state_i.running_sum + rx_byte_i;
  assign seen_next = state_i.params_seen + 8'd1;
  assign nparams   = state_i.held_length - MinLength;

  always_comb begin
    clear_st       = '0;
    clear_st.phase = PH_HUNT1;
  end

  always_comb begin
    state_o  = state_i;
    emit_o   = 1'b0;
    result_o = '0;
    unique case (state_i.phase)
      PH_HUNT2: begin
        if (rx_byte_i != HeaderByte) begin
          emit_o              = 1'b1;
          result_o.error_code = ERR_HEADER2;
          state_o             = clear_st;
        end else begin
          state_o.phase = PH_ID;
        end
      end
      PH_ID: begin
        state_o.held_id     = rx_byte_i;
        state_o.running_sum = rx_byte_i;
        state_o.phase       = PH_LEN;
      end
      PH_LEN: begin
        if (rx_byte_i < MinLength) begin
          emit_o              = 1'b1;
          result_o.error_code = ERR_LENGTH;
          state_o             = clear_st;
        end else begin
          state_o.held_length = rx_byte_i;
          state_o.running_sum = sum_next;
          state_o.phase       = PH_INSTR;
        end
      end
      PH_INSTR: begin
        state_o.held_instruction = rx_byte_i;
        state_o.running_sum      = sum_next;
        state_o.params_seen      = '0;
        state_o.phase = (state_i.held_length == MinLength) ? PH_CSUM : PH_PARAM;
      end
      PH_PARAM: begin
        if (state_i.params_seen < 8'(NumKept)) begin
          state_o.held_params[state_i.params_seen[1:0]] = rx_byte_i;
        end
        state_o.running_sum = sum_next;
        state_o.params_seen = seen_next;
        if (seen_next >= nparams) begin
          state_o.phase = PH_CSUM;
        end
      end
      PH_CSUM: begin
        emit_o  = 1'b1;
        state_o = clear_st;
        if (~state_i.running_sum != rx_byte_i) begin
          result_o.error_code = ERR_CHECKSUM;
        end else begin
          result_o.error_code   = ERR_NONE;
          result_o.device_id    = state_i.held_id;
          result_o.instruction  = state_i.held_instruction;
          result_o.param_first  = state_i.held_params[0];
          result_o.param_second = state_i.held_params[1];
          result_o.param_third  = state_i.held_params[2];
          result_o.param_count  = nparams;
        end
      end
      default: begin
        if (rx_byte_i != HeaderByte) begin
          emit_o              = 1'b1;
          result_o.error_code = ERR_HEADER1;
          state_o             = clear_st;
        end else begin
          state_o       = clear_st;
          state_o.phase = PH_HUNT2;
        end
      end
    endcase
  end

endmodule

// ===== src/servo_instruction_packet_parser.sv =====
// Channel   Dir  Payload                                    Transaction
// byte_i    in   rx_byte                                    one received byte
// res_o     out  error_code, device_id, instruction,        one packet result
//                param_first..third, param_count
//
// A byte is registered on acceptance and parsed from the input register; a
// result is registered in the output register before it appears on res_o.
// One byte per cycle is accepted for as long as results are taken.
// While res_o is stalled, bytes that produce no result keep flowing; a byte
// that produces a result waits in the input register until the output frees.
// Reset returns the parser to hunting the first header byte with nothing held.
module servo_instruction_packet_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  sipp_byte_if.sink     byte_i,
  sipp_result_if.source res_o
);
  import sipp_pkg::*;

  logic         in_vld_q;
  logic [7:0]   in_byte_q;
  parse_state_t st_q, st_d;
  logic         emit;
  result_t      res_d;
  logic         out_vld_q;
  result_t      out_res_q;
  logic         out_free;
  logic         fire;

  sipp_step u_step (
    .state_i   (st_q),
    .rx_byte_i (in_byte_q),
    .state_o   (st_d),
    .emit_o    (emit),
    .result_o  (res_d)
  );

  assign out_free     = !out_vld_q || res_o.ready;
  assign fire         = in_vld_q && (!emit || out_free);
  assign byte_i.ready = !in_vld_q || fire;
  assign res_o.valid  = out_vld_q;
  assign res_o.result = out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q       <= 1'b0;
      out_vld_q      <= 1'b0;
      st_q           <= '0;
    end else begin
      if (byte_i.ready) begin
        in_vld_q <= byte_i.valid;
      end
      if (fire) begin
        st_q <= st_d;
      end
      if (fire && emit) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.rx_byte;
    end
    if (fire && emit) begin
      out_res_q <= res_d;
    end
  end

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_res_q.error_code != ERR_NONE) |->
      (out_res_q.device_id == 8'd0 && out_res_q.instruction == 8'd0 &&
       out_res_q.param_first == 8'd0 && out_res_q.param_count == 8'd0))
    else $error("error result carries nonzero fields");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase <= PH_CSUM)
    else $error("parser reached an unused phase");

  a_held_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !fire) |=> (in_vld_q && $stable(in_byte_q)))
    else $error("input register lost a byte that was not parsed");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit) |=> out_vld_q)
    else $error("parsed result did not reach the output register");

endmodule
